// File: rtl/gaze_angle_to_screen_smoother_macros.svh
// Assertion macros used by the checker of the gaze smoother.
`ifndef GAZE_ANGLE_TO_SCREEN_SMOOTHER_MACROS_SVH
`define GAZE_ANGLE_TO_SCREEN_SMOOTHER_MACROS_SVH

// Same-cycle implication, sampled on clk and switched off while rst_n is low.
`define GATS_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gaze smoother check failed");

// Next-cycle implication, sampled on clk and switched off while rst_n is low.
`define GATS_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gaze smoother check failed");

`endif

// File: rtl/gats_pkg.sv
// Shared constants, types and the arctangent table of the gaze smoother.
`default_nettype none

package gats_pkg;

    localparam int DATA_W       = 16;
    localparam int CORDIC_STEPS = 16;
    localparam int ATAN_TBL_LEN = 24;
    localparam int CORDIC_ITERS = (CORDIC_STEPS > ATAN_TBL_LEN) ? ATAN_TBL_LEN : CORDIC_STEPS;
    localparam int ITER_W       = $clog2(CORDIC_ITERS);
    localparam int TBL_IDX_W    = $clog2(ATAN_TBL_LEN);
    localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(CORDIC_ITERS - 1);

    // Vector components carry 14 extra fraction bits; the angle is in 2^-30 rad.
    localparam int VEC_W     = 34;
    localparam int PRE_SHIFT = 14;
    localparam int ACC_W     = 34;
    localparam int ANGLE_W   = 17;
    localparam int ANGLE_LSB = 17;
    localparam int PROD_W    = 34;

    localparam logic signed [ACC_W-1:0]  HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [ACC_W-1:0]  ANGLE_RND   = 34'sd65536;
    localparam logic signed [PROD_W-1:0] NDC_HALF    = 34'sd134217728;
    localparam logic signed [PROD_W-1:0] MAP_RND     = 34'sd2048;
    localparam int                       MAP_SHIFT   = 12;
    localparam logic signed [PROD_W-1:0] BLEND_RND   = 34'sd32768;
    localparam int                       BLEND_SHIFT = 16;
    localparam logic signed [PROD_W-1:0] SAT_MAX     = 34'sd65535;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_H_GAIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_V_GAIN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA  = 2'd2;

    localparam logic [DATA_W-1:0] H_GAIN_RESET = 16'd18774;
    localparam logic [DATA_W-1:0] V_GAIN_RESET = 16'd20861;
    localparam logic [DATA_W-1:0] ALPHA_RESET  = 16'd16384;
    localparam logic [DATA_W-1:0] LAST_RESET   = 16'd32768;

    typedef struct packed {
        logic                     sample_valid;
        logic signed [DATA_W-1:0] dir_x;
        logic signed [DATA_W-1:0] dir_y;
        logic signed [DATA_W-1:0] dir_z;
    } gats_item_t;

    typedef struct packed {
        logic [DATA_W-1:0] h_gain;
        logic [DATA_W-1:0] v_gain;
        logic [DATA_W-1:0] alpha;
    } gats_cfg_t;

    typedef struct packed {
        logic                     start;
        logic signed [DATA_W-1:0] num;
        logic signed [DATA_W-1:0] den;
    } gats_cordic_req_t;

    typedef struct packed {
        logic                      done;
        logic signed [ANGLE_W-1:0] angle;
    } gats_cordic_rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_WAIT,
        ST_SCALE,
        ST_MAP,
        ST_BLEND,
        ST_SMOOTH,
        ST_DONE
    } gats_state_t;

    // atan(2^-i) in units of 2^-30 rad.
    function automatic logic signed [ACC_W-1:0] atan_q30(input logic [TBL_IDX_W-1:0] idx);
        logic signed [ACC_W-1:0] val;
        unique case (idx)
            5'd0:    val = 34'sd843314857;
            5'd1:    val = 34'sd497837829;
            5'd2:    val = 34'sd263043837;
            5'd3:    val = 34'sd133525159;
            5'd4:    val = 34'sd67021687;
            5'd5:    val = 34'sd33543516;
            5'd6:    val = 34'sd16775851;
            5'd7:    val = 34'sd8388437;
            5'd8:    val = 34'sd4194283;
            5'd9:    val = 34'sd2097149;
            5'd10:   val = 34'sd1048576;
            5'd11:   val = 34'sd524288;
            5'd12:   val = 34'sd262144;
            5'd13:   val = 34'sd131072;
            5'd14:   val = 34'sd65536;
            5'd15:   val = 34'sd32768;
            5'd16:   val = 34'sd16384;
            5'd17:   val = 34'sd8192;
            5'd18:   val = 34'sd4096;
            5'd19:   val = 34'sd2048;
            5'd20:   val = 34'sd1024;
            5'd21:   val = 34'sd512;
            5'd22:   val = 34'sd256;
            5'd23:   val = 34'sd128;
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

// File: rtl/gats_front.sv
// Input stage: accepts sample words into a short queue ahead of the back end.
`default_nettype none

module gats_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  gats_pkg::gats_item_t in_item,
    output logic                deq_valid,
    input  logic                deq_ready,
    output gats_pkg::gats_item_t deq_item
);
    import gats_pkg::*;

    gats_item_t          mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;
    logic                push;
    logic                pop;

    assign in_ready  = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign deq_valid = (count_reg != '0);
    assign deq_item  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = deq_valid && deq_ready;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

`default_nettype wire

// File: rtl/gats_cordic.sv
// Iterative vectoring CORDIC: one micro-rotation per cycle, then rounding to Q3.13.
`default_nettype none

module gats_cordic (
    input  logic                      clk,
    input  logic                      rst_n,
    input  gats_pkg::gats_cordic_req_t req,
    output gats_pkg::gats_cordic_rsp_t rsp
);
    import gats_pkg::*;

    logic signed [VEC_W-1:0]   a_reg;
    logic signed [VEC_W-1:0]   b_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic [ITER_W-1:0]         iter_reg;
    logic                      zero_reg;
    logic                      busy_reg;
    logic                      round_reg;
    logic                      done_reg;
    logic signed [ANGLE_W-1:0] angle_reg;

    logic signed [VEC_W-1:0]   a_next;
    logic signed [VEC_W-1:0]   b_next;
    logic signed [ACC_W-1:0]   acc_next;
    logic [ITER_W-1:0]         iter_next;
    logic signed [ANGLE_W-1:0] angle_next;

    logic signed [VEC_W-1:0]   num_sh;
    logic signed [VEC_W-1:0]   den_sh;
    logic signed [VEC_W-1:0]   da;
    logic signed [VEC_W-1:0]   db;
    logic signed [ACC_W-1:0]   step_ang;
    logic signed [ACC_W-1:0]   rnd_sum;

    assign num_sh   = VEC_W'(req.num) <<< PRE_SHIFT;
    assign den_sh   = VEC_W'(req.den) <<< PRE_SHIFT;
    assign da       = b_reg >>> iter_reg;
    assign db       = a_reg >>> iter_reg;
    assign step_ang = atan_q30(TBL_IDX_W'(iter_reg));
    assign rnd_sum  = acc_reg + ANGLE_RND;

    always_comb
    begin
        a_next     = a_reg;
        b_next     = b_reg;
        acc_next   = acc_reg;
        iter_next  = iter_reg;
        angle_next = angle_reg;
        if (req.start)
        begin
            iter_next = '0;
            // A vector in the left half plane is first turned by a quarter turn.
            if (den_sh[VEC_W-1] && !num_sh[VEC_W-1])
            begin
                a_next   = num_sh;
                b_next   = -den_sh;
                acc_next = HALF_PI_Q30;
            end
            else if (den_sh[VEC_W-1])
            begin
                a_next   = -num_sh;
                b_next   = den_sh;
                acc_next = -HALF_PI_Q30;
            end
            else
            begin
                a_next   = den_sh;
                b_next   = num_sh;
                acc_next = '0;
            end
        end
        else if (busy_reg)
        begin
            iter_next = iter_reg + 1'b1;
            if (!b_reg[VEC_W-1])
            begin
                a_next   = a_reg + da;
                b_next   = b_reg - db;
                acc_next = acc_reg + step_ang;
            end
            else
            begin
                a_next   = a_reg - da;
                b_next   = b_reg + db;
                acc_next = acc_reg - step_ang;
            end
        end
        else if (round_reg)
        begin
            angle_next = zero_reg ? '0 : rnd_sum[ANGLE_LSB +: ANGLE_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            round_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            if (req.start)
            begin
                busy_reg  <= 1'b1;
                round_reg <= 1'b0;
                done_reg  <= 1'b0;
            end
            else if (busy_reg && (iter_reg == ITER_LAST))
            begin
                busy_reg  <= 1'b0;
                round_reg <= 1'b1;
                done_reg  <= 1'b0;
            end
            else
            begin
                round_reg <= 1'b0;
                done_reg  <= round_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg     <= a_next;
        b_reg     <= b_next;
        acc_reg   <= acc_next;
        iter_reg  <= iter_next;
        angle_reg <= angle_next;
        if (req.start)
        begin
            zero_reg <= (req.num == '0) && (req.den == '0);
        end
    end

    assign rsp.done  = done_reg;
    assign rsp.angle = angle_reg;

endmodule

`default_nettype wire

// File: rtl/gats_back.sv
// Back end: sequences both angles through the CORDIC, scales, maps and smooths them.
`default_nettype none

module gats_back (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      deq_valid,
    output logic                      deq_ready,
    input  gats_pkg::gats_item_t       deq_item,
    input  gats_pkg::gats_cfg_t        cfg,
    output gats_pkg::gats_cordic_req_t cordic_req,
    input  gats_pkg::gats_cordic_rsp_t cordic_rsp,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [gats_pkg::DATA_W-1:0] screen_x,
    output logic [gats_pkg::DATA_W-1:0] screen_y
);
    import gats_pkg::*;

    gats_state_t state_reg;
    gats_state_t state_next;

    logic signed [DATA_W-1:0] x_reg;
    logic signed [DATA_W-1:0] y_reg;
    logic signed [DATA_W-1:0] z_reg;
    logic                     axis_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic [DATA_W-1:0]        target_reg;
    logic [DATA_W-1:0]        last_x_reg;
    logic [DATA_W-1:0]        last_y_reg;
    logic                     out_valid_reg;
    logic [DATA_W-1:0]        screen_x_reg;
    logic [DATA_W-1:0]        screen_y_reg;

    logic [DATA_W-1:0]        gain;
    logic [DATA_W-1:0]        last_sel;
    logic signed [PROD_W-1:0] scale_prod;
    logic signed [PROD_W-1:0] map_t;
    logic signed [PROD_W-1:0] map_sh;
    logic [DATA_W-1:0]        target_next;
    logic signed [DATA_W:0]   diff;
    logic signed [PROD_W-1:0] blend_prod;
    logic signed [PROD_W-1:0] blend_sh;
    logic signed [PROD_W-1:0] smooth_sum;
    logic [DATA_W-1:0]        smooth_next;
    logic                     out_free;

    assign gain     = axis_reg ? cfg.v_gain : cfg.h_gain;
    assign last_sel = axis_reg ? last_y_reg : last_x_reg;
    assign out_free = !out_valid_reg || out_ready;

    assign scale_prod = $signed(cordic_rsp.angle) * $signed({1'b0, gain});

    // The vertical axis is flipped so that looking up moves toward the top.
    assign map_t  = axis_reg ? (NDC_HALF - prod_reg) : (prod_reg + NDC_HALF);
    assign map_sh = (map_t + MAP_RND) >>> MAP_SHIFT;

    always_comb
    begin
        if (map_sh[PROD_W-1])
        begin
            target_next = '0;
        end
        else if (map_sh > SAT_MAX)
        begin
            target_next = '1;
        end
        else
        begin
            target_next = map_sh[DATA_W-1:0];
        end
    end

    assign diff       = $signed({1'b0, target_reg}) - $signed({1'b0, last_sel});
    assign blend_prod = $signed({1'b0, cfg.alpha}) * diff;
    assign blend_sh   = (prod_reg + BLEND_RND) >>> BLEND_SHIFT;
    assign smooth_sum = blend_sh + $signed({{(PROD_W - DATA_W){1'b0}}, last_sel});

    always_comb
    begin
        if (smooth_sum[PROD_W-1])
        begin
            smooth_next = '0;
        end
        else if (smooth_sum > SAT_MAX)
        begin
            smooth_next = '1;
        end
        else
        begin
            smooth_next = smooth_sum[DATA_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        deq_ready        = 1'b0;
        cordic_req.start = 1'b0;
        cordic_req.num   = axis_reg ? y_reg : x_reg;
        cordic_req.den   = z_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                deq_ready = 1'b1;
                if (deq_valid)
                begin
                    state_next = deq_item.sample_valid ? ST_START : ST_DONE;
                end
            end
            ST_START:
            begin
                cordic_req.start = 1'b1;
                state_next       = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (cordic_rsp.done)
                begin
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE:
            begin
                state_next = ST_MAP;
            end
            ST_MAP:
            begin
                state_next = ST_BLEND;
            end
            ST_BLEND:
            begin
                state_next = ST_SMOOTH;
            end
            ST_SMOOTH:
            begin
                state_next = axis_reg ? ST_DONE : ST_START;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_x_reg    <= LAST_RESET;
            last_y_reg    <= LAST_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == ST_SMOOTH)
            begin
                if (axis_reg)
                begin
                    last_y_reg <= smooth_next;
                end
                else
                begin
                    last_x_reg <= smooth_next;
                end
            end
            if ((state_reg == ST_DONE) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_IDLE) && deq_valid)
        begin
            x_reg    <= deq_item.dir_x;
            y_reg    <= deq_item.dir_y;
            z_reg    <= deq_item.dir_z;
            axis_reg <= 1'b0;
        end
        else if (state_reg == ST_SMOOTH)
        begin
            axis_reg <= 1'b1;
        end
        if (state_reg == ST_SCALE)
        begin
            prod_reg <= scale_prod;
        end
        else if (state_reg == ST_BLEND)
        begin
            prod_reg <= blend_prod;
        end
        if (state_reg == ST_MAP)
        begin
            target_reg <= target_next;
        end
        if ((state_reg == ST_DONE) && out_free)
        begin
            screen_x_reg <= last_x_reg;
            screen_y_reg <= last_y_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign screen_x  = screen_x_reg;
    assign screen_y  = screen_y_reg;

endmodule

`default_nettype wire

// File: rtl/gaze_angle_to_screen_smoother.sv
// Top level of the gaze angle to screen position smoother.
//
//  Channel  Handshake               Word
//  -------  ----------------------  -------------------------------------------
//  in       in_valid / in_ready     sample_valid, dir_x, dir_y, dir_z
//  out      out_valid / out_ready   screen_x, screen_y
//  cfg      cfg_wr_en (no wait)     cfg_index, cfg_wdata
//
// In the back end one shared CORDIC unit resolves the two angles of a valid sample in turn,
// one micro-rotation per cycle. An invalid sample skips the CORDIC and the arithmetic.
// A two-word queue takes input while the back end works.
// Reset is asynchronous and active low; no clearing pass follows it.
// A stalled output holds its word while the back end goes on with the next one.
`default_nettype none

module gaze_angle_to_screen_smoother (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               sample_valid,
    input  logic signed [gats_pkg::DATA_W-1:0] dir_x,
    input  logic signed [gats_pkg::DATA_W-1:0] dir_y,
    input  logic signed [gats_pkg::DATA_W-1:0] dir_z,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [gats_pkg::DATA_W-1:0]        screen_x,
    output logic [gats_pkg::DATA_W-1:0]        screen_y,
    input  logic                               cfg_wr_en,
    input  logic [gats_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [gats_pkg::DATA_W-1:0]        cfg_wdata
);
    import gats_pkg::*;

    gats_cfg_t        cfg_reg;
    gats_item_t       in_item;
    gats_item_t       deq_item;
    logic             deq_valid;
    logic             deq_ready;
    gats_cordic_req_t cordic_req;
    gats_cordic_rsp_t cordic_rsp;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.h_gain <= H_GAIN_RESET;
            cfg_reg.v_gain <= V_GAIN_RESET;
            cfg_reg.alpha  <= ALPHA_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_H_GAIN: cfg_reg.h_gain <= cfg_wdata;
                REG_V_GAIN: cfg_reg.v_gain <= cfg_wdata;
                REG_ALPHA:  cfg_reg.alpha  <= cfg_wdata;
                default:    cfg_reg        <= cfg_reg;
            endcase
        end
    end

    assign in_item.sample_valid = sample_valid;
    assign in_item.dir_x        = dir_x;
    assign in_item.dir_y        = dir_y;
    assign in_item.dir_z        = dir_z;

    gats_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .deq_valid (deq_valid),
        .deq_ready (deq_ready),
        .deq_item  (deq_item)
    );

    gats_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (cordic_req),
        .rsp   (cordic_rsp)
    );

    gats_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .deq_valid  (deq_valid),
        .deq_ready  (deq_ready),
        .deq_item   (deq_item),
        .cfg        (cfg_reg),
        .cordic_req (cordic_req),
        .cordic_rsp (cordic_rsp),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .screen_x   (screen_x),
        .screen_y   (screen_y)
    );

endmodule

`default_nettype wire

// File: rtl/gats_checker.sv
// Port-level checker for the gaze smoother, bound to the top level.
`default_nettype none
`include "gaze_angle_to_screen_smoother_macros.svh"

module gats_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [15:0] screen_x,
    input  logic [15:0] screen_y
);
    // Queue, back end and output register together hold at most four words.
    localparam logic [2:0] CAPACITY = 3'd4;

    logic [2:0] pending_reg;
    logic       in_fire;
    logic       out_fire;

    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else if (in_fire && !out_fire)
        begin
            pending_reg <= pending_reg + 1'b1;
        end
        else if (out_fire && !in_fire)
        begin
            pending_reg <= pending_reg - 1'b1;
        end
    end

    `GATS_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid)
    `GATS_ASSERT_NXT(a_out_stable, out_valid && !out_ready, $stable(screen_x) && $stable(screen_y))
    `GATS_ASSERT_IMP(a_out_has_source, out_valid, pending_reg != 3'd0)
    `GATS_ASSERT_IMP(a_full_stalls_input, pending_reg == CAPACITY, !in_ready)

endmodule

bind gaze_angle_to_screen_smoother gats_checker u_checker (.*);

`default_nettype wire

// File: test/tb.sv
// Self-checking testbench for the gaze angle to screen position smoother.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import gats_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
    localparam int  N_DIRECTED     = 21;
    localparam int  N_PHASES       = 8;
    localparam int  PHASE_WORDS    = 125;
    localparam int  DRAIN_CYCLES   = 60;
    localparam int  WATCHDOG_LIMIT = 5000;
    localparam longint HALF_PI_RAD_Q30 = 64'sd1686629713;

    // atan(2^-i) in units of 2^-30 rad.
    localparam longint ATAN_STEP_Q30 [24] = '{
        843314857, 497837829, 263043837, 133525159,
        67021687, 33543516, 16775851, 8388437,
        4194283, 2097149, 1048576, 524288,
        262144, 131072, 65536, 32768,
        16384, 8192, 4096, 2048,
        1024, 512, 256, 128
    };

    typedef struct packed {
        logic [DATA_W-1:0] x;
        logic [DATA_W-1:0] y;
    } screen_pos_t;

    typedef struct packed {
        gats_item_t  word;
        logic        typed;
        screen_pos_t pos;
    } gaze_row_t;

    // Rows with a typed position are read straight off the reset state.
    localparam gaze_row_t DIRECTED [N_DIRECTED] = '{
        '{'{1'b0, 16'sd0, 16'sd0, 16'sd0}, 1'b1, '{16'd32768, 16'd32768}},
        '{'{1'b1, 16'sd0, 16'sd0, 16'sd0}, 1'b1, '{16'd32768, 16'd32768}},
        '{'{1'b1, 16'sd32767, 16'sd32767, 16'sd32767}, 1'b0, '{16'd0, 16'd0}},
        '{'{1'b1, 16'sh8000, 16'sh8000, 16'sd32767}, 1'b0, '{16'd0, 16'd0}},
        '{'{1'b1, 16'sd32767, 16'sh8000, 16'sd0}, 1'b0, '{16'd0, 16'd0}},
        '{'{1'b1, 16'sd0, 16'sd0, 16'sh8000}, 1'b0, '{16'd0, 16'd0}},
        '{'{1'b1, 16'sd0, 16'sd0, -16'sd1}, 1'b0, '{16'd0, 16'd0}},
        '{'{1'b1, 16'sd12000, -16'sd12000, -16'sd20000}, 1'b0, '{16'd0, 16'd0}},
        '{'{1'b1, 16'sh8000, 16'sd32767, 16'sh8000}, 1'b0, '{16'd0, 16'd0}},
        '{'{1'b1, 16'sd32767, 16'sd32767, 16'sh8000}, 1'b0, '{16'd0, 16'd0}},
        '{'{1'b1, 16'sd0, 16'sd32767, 16'sd0}, 1'b0, '{16'd0, 16'd0}},
        '{'{1'b1, -16'sd1, 16'sd1, 16'sd32767}, 1'b0, '{16'd0, 16'd0}},
        '{'{1'b0, 16'sd32767, 16'sh8000, -16'sd1}, 1'b0, '{16'd0, 16'd0}},
        '{'{1'b1, 16'sd0, 16'sd0, 16'sd32767}, 1'b0, '{16'd0, 16'd0}},
        '{'{1'b1, 16'sh8000, 16'sh8000, 16'sh8000}, 1'b0, '{16'd0, 16'd0}},
        '{'{1'b1, 16'sd1, -16'sd1, 16'sd0}, 1'b0, '{16'd0, 16'd0}},
        '{'{1'b1, 16'sd23170, -16'sd23170, 16'sd23170}, 1'b0, '{16'd0, 16'd0}},
        '{'{1'b1, 16'sd0, 16'sh8000, 16'sd0}, 1'b0, '{16'd0, 16'd0}},
        '{'{1'b0, 16'sh8000, 16'sd32767, 16'sd0}, 1'b0, '{16'd0, 16'd0}},
        '{'{1'b1, 16'sd32767, 16'sd0, 16'sd1}, 1'b0, '{16'd0, 16'd0}},
        '{'{1'b1, 16'sh8000, 16'sd0, -16'sd1}, 1'b0, '{16'd0, 16'd0}}
    };

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_ready;
    logic                     sample_valid;
    logic signed [DATA_W-1:0] dir_x;
    logic signed [DATA_W-1:0] dir_y;
    logic signed [DATA_W-1:0] dir_z;
    logic                     out_valid;
    logic                     out_ready;
    logic [DATA_W-1:0]        screen_x;
    logic [DATA_W-1:0]        screen_y;
    logic                     cfg_wr_en;
    logic [CFG_IDX_W-1:0]     cfg_index;
    logic [DATA_W-1:0]        cfg_wdata;

    // Predictor state and register copies.
    logic [DATA_W-1:0] h_gain_q14;
    logic [DATA_W-1:0] v_gain_q14;
    logic [DATA_W-1:0] alpha_q16;
    logic [DATA_W-1:0] pos_x;
    logic [DATA_W-1:0] pos_y;

    screen_pos_t pending_pos[$];
    int          mismatch_count;
    int          quiet_cycles;
    bit          idling;

    gaze_angle_to_screen_smoother uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .sample_valid (sample_valid),
        .dir_x        (dir_x),
        .dir_y        (dir_y),
        .dir_z        (dir_z),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .screen_x     (screen_x),
        .screen_y     (screen_y),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = ~clk;
        end
    end

    // Vectoring CORDIC; the result is the angle in signed Q3.13 radians.
    function automatic longint gaze_angle_q13(longint num, longint den);
        longint a;
        longint b;
        longint acc;
        longint t;
        longint da;
        longint db;
        int     steps;
        a = den * 16384;
        b = num * 16384;
        acc = 0;
        if (num == 0 && den == 0)
            return 0;
        if (a < 0)
        begin
            t = a;
            if (b >= 0)
            begin
                a = b;
                b = -t;
                acc = HALF_PI_RAD_Q30;
            end
            else
            begin
                a = -b;
                b = t;
                acc = -HALF_PI_RAD_Q30;
            end
        end
        steps = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
        for (int i = 0; i < steps; i++)
        begin
            da = b >>> i;
            db = a >>> i;
            if (b >= 0)
            begin
                a = a + da;
                b = b - db;
                acc = acc + ATAN_STEP_Q30[i];
            end
            else
            begin
                a = a - da;
                b = b + db;
                acc = acc - ATAN_STEP_Q30[i];
            end
        end
        return (acc + 65536) >>> 17;
    endfunction

    function automatic logic [DATA_W-1:0] clamp_q16(longint v);
        if (v < 0)
            return '0;
        if (v > 65535)
            return 16'hFFFF;
        return v[DATA_W-1:0];
    endfunction

    function automatic logic [DATA_W-1:0] ease_toward(logic [DATA_W-1:0] last,
                                                      logic [DATA_W-1:0] target);
        longint diff;
        diff = longint'(target) - longint'(last);
        return clamp_q16(longint'(last) + ((longint'(alpha_q16) * diff + 32768) >>> 16));
    endfunction

    function automatic screen_pos_t track_gaze(gats_item_t w);
        longint            ang_u;
        longint            ang_v;
        logic [DATA_W-1:0] tx;
        logic [DATA_W-1:0] ty;
        screen_pos_t       r;
        if (w.sample_valid)
        begin
            ang_u = gaze_angle_q13(longint'(w.dir_x), longint'(w.dir_z));
            ang_v = gaze_angle_q13(longint'(w.dir_y), longint'(w.dir_z));
            tx = clamp_q16((ang_u * longint'(h_gain_q14) + 134217728 + 2048) >>> 12);
            ty = clamp_q16((134217728 - ang_v * longint'(v_gain_q14) + 2048) >>> 12);
            pos_x = ease_toward(pos_x, tx);
            pos_y = ease_toward(pos_y, ty);
        end
        r.x = pos_x;
        r.y = pos_y;
        return r;
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_component();
        logic signed [DATA_W-1:0] v;
        case ($urandom_range(0, 5))
            0, 1: v = DATA_W'($urandom);
            2:    v = DATA_W'($urandom_range(0, 600) - 300);
            3:
            begin
                case ($urandom_range(0, 4))
                    0:       v = 16'sh8000;
                    1:       v = 16'sh7FFF;
                    2:       v = 16'sd0;
                    3:       v = -16'sd1;
                    default: v = 16'sd1;
                endcase
            end
            4:       v = {($urandom_range(0, 1) != 0) ? 2'b01 : 2'b10, 14'($urandom)};
            default: v = DATA_W'($urandom_range(0, 32767));
        endcase
        return v;
    endfunction

    task automatic send_word(gats_item_t w, logic typed, screen_pos_t typed_pos);
        int          gap;
        screen_pos_t guess;
        gap = 0;
        if (idling && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 9);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        sample_valid <= w.sample_valid;
        dir_x        <= w.dir_x;
        dir_y        <= w.dir_y;
        dir_z        <= w.dir_z;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        guess = track_gaze(w);
        pending_pos.push_back(typed ? typed_pos : guess);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_pos.size() != 0)
            @(posedge clk);
    endtask

    // Writes the three registers and a spare index that the block must ignore.
    task automatic program_regs(logic [DATA_W-1:0] h, logic [DATA_W-1:0] v,
                                logic [DATA_W-1:0] a);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_H_GAIN;
        cfg_wdata <= h;
        @(posedge clk);
        h_gain_q14 = h;
        cfg_index <= REG_V_GAIN;
        cfg_wdata <= v;
        @(posedge clk);
        v_gain_q14 = v;
        cfg_index <= REG_ALPHA;
        cfg_wdata <= a;
        @(posedge clk);
        alpha_q16 = a;
        cfg_index <= REG_SPARE;
        cfg_wdata <= DATA_W'($urandom);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    // Receiver: random stall bursts on out_ready.
    initial
    begin
        int stall_left;
        stall_left = 0;
        out_ready <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
                stall_left--;
            else if (idling && $urandom_range(0, 5) == 0)
                stall_left = $urandom_range(1, 9);
            out_ready <= (stall_left == 0);
        end
    end

    always @(posedge clk)
    begin
        screen_pos_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_pos.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected screen word: x=%0d y=%0d", screen_x, screen_y);
            end
            else
            begin
                want = pending_pos.pop_front();
                if (screen_x !== want.x || screen_y !== want.y)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("screen word mismatch: expected x=%0d y=%0d, got x=%0d y=%0d",
                                 want.x, want.y, screen_x, screen_y);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("tb NOT OK");
        $finish;
    end

    initial
    begin
        gats_item_t        w;
        logic [DATA_W-1:0] h;
        logic [DATA_W-1:0] v;
        logic [DATA_W-1:0] a;
        screen_pos_t       none;
        mismatch_count = 0;
        quiet_cycles   = 0;
        idling         = 1'b1;
        none           = '0;
        h_gain_q14     = H_GAIN_RESET;
        v_gain_q14     = V_GAIN_RESET;
        alpha_q16      = ALPHA_RESET;
        pos_x          = LAST_RESET;
        pos_y          = LAST_RESET;
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        sample_valid <= 1'b0;
        dir_x        <= '0;
        dir_y        <= '0;
        dir_z        <= '0;
        cfg_wr_en    <= 1'b0;
        cfg_index    <= REG_H_GAIN;
        cfg_wdata    <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int k = 0; k < N_DIRECTED; k++)
            send_word(DIRECTED[k].word, DIRECTED[k].typed, DIRECTED[k].pos);

        for (int p = 0; p < N_PHASES; p++)
        begin
            wait_drained();
            case (p)
                0:
                begin
                    h = H_GAIN_RESET;
                    v = V_GAIN_RESET;
                    a = ALPHA_RESET;
                end
                1:
                begin
                    h = '0;
                    v = '0;
                    a = '0;
                end
                2:
                begin
                    h = 16'hFFFF;
                    v = 16'hFFFF;
                    a = 16'hFFFF;
                end
                4:
                begin
                    h = DATA_W'($urandom);
                    v = DATA_W'($urandom);
                    a = 16'hFFFF;
                end
                7:
                begin
                    h = H_GAIN_RESET;
                    v = V_GAIN_RESET;
                    a = DATA_W'($urandom_range(8192, 65535));
                end
                default:
                begin
                    h = DATA_W'($urandom);
                    v = DATA_W'($urandom);
                    a = DATA_W'($urandom);
                end
            endcase
            program_regs(h, v, a);
            // One phase runs without idling, and the closing phase too.
            idling = (p != 5 && p != N_PHASES - 1);
            for (int k = 0; k < PHASE_WORDS; k++)
            begin
                w.sample_valid = ($urandom_range(0, 9) != 0);
                w.dir_x = pick_component();
                w.dir_y = pick_component();
                w.dir_z = pick_component();
                send_word(w, 1'b0, none);
                if (p == 3 && k == PHASE_WORDS / 2)
                    wait_drained();
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_pos.size() != 0)
            mismatch_count++;
        if (mismatch_count == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
